FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KURD_ASSERT_NOW(label, clk, rst_n, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KURD_ASSERT_NEXT(label, clk, rst_n, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/kurd_pkg.sv
// Package for the keyed uniform random draw: word types, hash and twister
// constants, datapath command codes. No dependencies.
package kurd_pkg;

  localparam logic [63:0] GOLDEN_STEP  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
  localparam logic [63:0] SEED_BASE    = 64'h6a09e667f3bcc909;
  localparam logic [63:0] CELL_OFFSET  = 64'h243f6a8885a308d3;
  localparam logic [63:0] STEP_OFFSET  = 64'h13198a2e03707344;
  localparam logic [63:0] EVENT_OFFSET = 64'ha4093822299f31d0;
  localparam int          FRACTION_BITS = 53;

  // offset and golden step folded into one key per field
  localparam logic [63:0] CELL_KEY  = CELL_OFFSET + GOLDEN_STEP;
  localparam logic [63:0] STEP_KEY  = STEP_OFFSET + GOLDEN_STEP;
  localparam logic [63:0] EVENT_KEY = EVENT_OFFSET + GOLDEN_STEP;

  localparam logic [63:0] TW_INIT_MUL = 64'd6364136223846793005;
  localparam logic [63:0] TW_UPPER    = 64'hFFFFFFFF80000000;
  localparam logic [63:0] TW_LOWER    = 64'h000000007FFFFFFF;
  localparam logic [63:0] TW_MATRIX   = 64'hB5026F5AA96619E9;
  localparam logic [63:0] TW_MASK_B   = 64'h5555555555555555;
  localparam logic [63:0] TW_MASK_C   = 64'h71D67FFFEDA60000;
  localparam logic [63:0] TW_MASK_D   = 64'hFFF7EEE000000000;

  localparam int TW_MID = 156;
  localparam int STEP_W = $clog2(TW_MID + 1);
  localparam logic [STEP_W-1:0] TW_FIRST = STEP_W'(1);
  localparam logic [STEP_W-1:0] TW_LAST  = STEP_W'(TW_MID);

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_PRE   = 4'd2;
  localparam logic [3:0] OP_MUL0  = 4'd3;
  localparam logic [3:0] OP_MUL1  = 4'd4;
  localparam logic [3:0] OP_MUL2  = 4'd5;
  localparam logic [3:0] OP_MID   = 4'd6;
  localparam logic [3:0] OP_END   = 4'd7;
  localparam logic [3:0] OP_FIX   = 4'd8;
  localparam logic [3:0] OP_TWADD = 4'd9;
  localparam logic [3:0] OP_TEMP  = 4'd10;

  localparam logic [1:0] SEL_CELL  = 2'd0;
  localparam logic [1:0] SEL_STEP  = 2'd1;
  localparam logic [1:0] SEL_EVENT = 2'd2;

  localparam logic [1:0] MC_A    = 2'd0;
  localparam logic [1:0] MC_B    = 2'd1;
  localparam logic [1:0] MC_INIT = 2'd2;

  typedef struct packed {
    logic signed [63:0] cell_number;
    logic signed [63:0] step_number;
    logic signed [63:0] event_number;
  } in_word_t;

  typedef struct packed {
    logic [63:0]              seed_word;
    logic [63:0]              raw_word;
    logic [FRACTION_BITS-1:0] uniform_fraction;
  } out_word_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [1:0]        sel;
    logic [1:0]        mconst;
    logic [STEP_W-1:0] step;
  } cmd_t;

endpackage

FILE: hw/rtl/keyed_uniform_random_draw.sv
// Keyed uniform random draw: three 64-bit ids are hashed into one
// nonzero seed, the seed starts a 64-bit Mersenne Twister and the first
// tempered word comes back with a 0.53 fraction. An item is taken when start
// is high and busy is low; busy then stays high until the draw is done, and
// the result appears on out_word with out_strobe, high for exactly one cycle,
// in the first cycle with busy low again. The receiver cannot stall: capture
// it then. One 32x32 multiplier builds each 64-bit product from a low and
// two cross partial products: six products for the hash and 156 chained
// seeding steps of a product and an add each. A new start is taken in the
// same cycle as the strobe. Depends on kurd_pkg, kurd_ctrl and kurd_datapath.
module keyed_uniform_random_draw (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kurd_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output kurd_pkg::out_word_t out_word
);
  import kurd_pkg::*;

  cmd_t cmd;

  kurd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  kurd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

FILE: hw/rtl/kurd_datapath.sv
// Datapath: input hold, shared 32x32 multiplier with 64-bit accumulate,
// seed hashing, twister seeding registers, tempering and the result register.
// Depends on kurd_pkg.
module kurd_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  kurd_pkg::cmd_t     cmd,
  input  kurd_pkg::in_word_t in_word,
  output logic               out_strobe,
  output kurd_pkg::out_word_t out_word
);
  import kurd_pkg::*;

  in_word_t  in_r;
  logic [63:0] v_r, prod_r, seed_r, cur_r, w1_r;
  out_word_t out_r;
  logic      strobe_r, strobe_nxt;

  logic [63:0] sel_in, sel_key, pre_x, mul_b, mprod;
  logic [31:0] ma, mb;
  logic [63:0] seed_fixed, cur_new, tw_y, tw_t0, tw_t1, tw_t2, tw_t3, tw_t4;

  always_comb begin
    case (cmd.sel)
      SEL_CELL: begin
        sel_in  = in_r.cell_number;
        sel_key = CELL_KEY;
      end
      SEL_STEP: begin
        sel_in  = in_r.step_number;
        sel_key = STEP_KEY;
      end
      default: begin
        sel_in  = in_r.event_number;
        sel_key = EVENT_KEY;
      end
    endcase
    pre_x = sel_in + sel_key;

    case (cmd.mconst)
      MC_A:    mul_b = MIX_MUL_A;
      MC_B:    mul_b = MIX_MUL_B;
      default: mul_b = TW_INIT_MUL;
    endcase

    case (cmd.op)
      OP_MUL1: begin
        ma = v_r[31:0];
        mb = mul_b[63:32];
      end
      OP_MUL2: begin
        ma = v_r[63:32];
        mb = mul_b[31:0];
      end
      default: begin
        ma = v_r[31:0];
        mb = mul_b[31:0];
      end
    endcase
    mprod = {32'd0, ma} * {32'd0, mb};

    seed_fixed = (seed_r == 64'd0) ? 64'd1 : seed_r;
    cur_new    = prod_r + {{(64-STEP_W){1'b0}}, cmd.step};

    tw_y  = (seed_r & TW_UPPER) | (w1_r & TW_LOWER);
    tw_t0 = cur_r ^ (tw_y >> 1) ^ (tw_y[0] ? TW_MATRIX : 64'd0);
    tw_t1 = tw_t0 ^ ((tw_t0 >> 29) & TW_MASK_B);
    tw_t2 = tw_t1 ^ ((tw_t1 << 17) & TW_MASK_C);
    tw_t3 = tw_t2 ^ ((tw_t2 << 37) & TW_MASK_D);
    tw_t4 = tw_t3 ^ (tw_t3 >> 43);

    strobe_nxt = (cmd.op == OP_TEMP);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        in_r   <= in_word;
        seed_r <= SEED_BASE;
      end
      OP_PRE:  v_r <= pre_x ^ (pre_x >> 30);
      OP_MUL0: prod_r <= mprod;
      OP_MUL1: prod_r <= prod_r + {mprod[31:0], 32'd0};
      OP_MUL2: prod_r <= prod_r + {mprod[31:0], 32'd0};
      OP_MID:  v_r <= prod_r ^ (prod_r >> 27);
      OP_END:  seed_r <= seed_r ^ prod_r ^ (prod_r >> 31);
      OP_FIX: begin
        seed_r <= seed_fixed;
        cur_r  <= seed_fixed;
        v_r    <= seed_fixed ^ (seed_fixed >> 62);
      end
      OP_TWADD: begin
        cur_r <= cur_new;
        v_r   <= cur_new ^ (cur_new >> 62);
        if (cmd.step == TW_FIRST) begin
          w1_r <= cur_new;
        end
      end
      OP_TEMP: begin
        out_r.seed_word        <= seed_r;
        out_r.raw_word         <= tw_t4;
        out_r.uniform_fraction <= tw_t4[63:64-FRACTION_BITS];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_word   = out_r;

endmodule

FILE: hw/rtl/kurd_ctrl.sv
// Controller: sequences the hash rounds, the multiplier phases and the
// twister seeding steps; issues one datapath command per cycle. Uses kurd_pkg.
module kurd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output kurd_pkg::cmd_t cmd
);
  import kurd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRE   = 4'd1;
  localparam logic [3:0] S_MULA  = 4'd2;
  localparam logic [3:0] S_MID   = 4'd3;
  localparam logic [3:0] S_MULB  = 4'd4;
  localparam logic [3:0] S_END   = 4'd5;
  localparam logic [3:0] S_FIX   = 4'd6;
  localparam logic [3:0] S_TWMUL = 4'd7;
  localparam logic [3:0] S_TWADD = 4'd8;
  localparam logic [3:0] S_TEMP  = 4'd9;

  localparam logic [1:0] PH_LO   = 2'd0;
  localparam logic [1:0] PH_HI_B = 2'd1;
  localparam logic [1:0] PH_HI_A = 2'd2;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [STEP_W-1:0] i_r, i_nxt;
  logic [3:0]        mul_op;
  logic              ph_done;

  always_comb begin
    case (ph_r)
      PH_LO:   mul_op = OP_MUL0;
      PH_HI_B: mul_op = OP_MUL1;
      default: mul_op = OP_MUL2;
    endcase
    ph_done = (ph_r == PH_HI_A);

    state_nxt  = state_r;
    k_nxt      = k_r;
    ph_nxt     = ph_r;
    i_nxt      = i_r;
    cmd.op     = OP_NONE;
    cmd.sel    = k_r;
    cmd.mconst = MC_A;
    cmd.step   = i_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          k_nxt     = SEL_CELL;
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        cmd.op    = OP_PRE;
        ph_nxt    = PH_LO;
        state_nxt = S_MULA;
      end
      S_MULA: begin
        cmd.op     = mul_op;
        cmd.mconst = MC_A;
        ph_nxt     = ph_done ? PH_LO : ph_r + 2'd1;
        if (ph_done) begin
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        cmd.op    = OP_MID;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.op     = mul_op;
        cmd.mconst = MC_B;
        ph_nxt     = ph_done ? PH_LO : ph_r + 2'd1;
        if (ph_done) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        cmd.op = OP_END;
        if (k_r == SEL_EVENT) begin
          state_nxt = S_FIX;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_PRE;
        end
      end
      S_FIX: begin
        cmd.op    = OP_FIX;
        i_nxt     = TW_FIRST;
        ph_nxt    = PH_LO;
        state_nxt = S_TWMUL;
      end
      S_TWMUL: begin
        cmd.op     = mul_op;
        cmd.mconst = MC_INIT;
        ph_nxt     = ph_done ? PH_LO : ph_r + 2'd1;
        if (ph_done) begin
          state_nxt = S_TWADD;
        end
      end
      S_TWADD: begin
        cmd.op = OP_TWADD;
        if (i_r == TW_LAST) begin
          state_nxt = S_TEMP;
        end else begin
          i_nxt     = i_r + TW_FIRST;
          state_nxt = S_TWMUL;
        end
      end
      S_TEMP: begin
        cmd.op    = OP_TEMP;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= SEL_CELL;
      ph_r    <= PH_LO;
      i_r     <= TW_FIRST;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ph_r    <= ph_nxt;
      i_r     <= i_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: hw/rtl/kurd_checker.sv
// Port-level checker for keyed_uniform_random_draw, bound to the top level.
// Depends on kurd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kurd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input kurd_pkg::out_word_t out_word
);
  import kurd_pkg::*;

  logic frac_ok;

  assign frac_ok = (out_word.uniform_fraction == out_word.raw_word[63:64-FRACTION_BITS]);

  `KURD_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised")
  `KURD_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe, "strobe over one cycle")
  `KURD_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_strobe, !busy, "result shown while busy")
  `KURD_ASSERT_NOW(a_seed_nonzero, clk, rst_n, out_strobe, out_word.seed_word != 64'd0, "zero seed")
  `KURD_ASSERT_NOW(a_fraction, clk, rst_n, out_strobe, frac_ok, "fraction mismatch")

endmodule

bind keyed_uniform_random_draw kurd_checker u_kurd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);
